[hdl/ffpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int NUM_PAGES   = 16384;
	localparam int MAX_EXTENTS = 64;
	localparam int PW          = 14;
	localparam int CW          = 15;
	localparam int IW          = $clog2(MAX_EXTENTS);
	localparam int UW          = $clog2(MAX_EXTENTS + 1);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_WR        = 3'd1,
		ACT_WR_REMOVE = 3'd2,
		ACT_REMOVE    = 3'd3,
		ACT_INSERT    = 3'd4
	} act_t;

	typedef struct packed {
		logic [PW-1:0] st;
		logic [CW-1:0] len;
	} ext_t;

	typedef struct packed {
		logic cap;
		logic scan;
		logic decide;
		logic wr_ent;
		logic sl_rd;
		logic sl_wr;
		logic sr_rd;
		logic sr_wr;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		act_t act;
		act_t act_q;
		logic sl_more;
		logic sr_more;
	} sts_t;

endpackage
`default_nettype wire

[hdl/first_fit_page_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_allocator_top
// First-fit page allocator with coalescing on free over an extent table.
// ----------------------------------------------------------------------------
// Sequence: after the input transfer the used entries are scanned and a decision is
// taken; then an in-place rewrite, a removal, or both for a two-sided merge, or an
// insert, moving table entries one at a time; then the result is presented.
// Throughput: one operation at a time; the next input transfer is taken no
// earlier than the cycle after the result transfer.
// Reset: the table is empty and the free total is zero; no clearing pass.
module first_fit_page_allocator_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               operation,
	input  wire logic [ffpa_pkg::PW-1:0]  start_page,
	input  wire logic [ffpa_pkg::CW-1:0]  page_count,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic [ffpa_pkg::PW-1:0]       granted_page,
	output logic [ffpa_pkg::CW-1:0]       free_total
);
	import ffpa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.start_page  (start_page),
		.page_count  (page_count),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.granted_page(granted_page),
		.free_total  (free_total)
	);

endmodule
`default_nettype wire

[hdl/ffpa_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Controller state machine: sequences scan, decision, table moves and result.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire ffpa_pkg::sts_t sts,
	output ffpa_pkg::cmd_t      cmd
);
	import ffpa_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SCAN = 10'b0000000010,
		S_DEC  = 10'b0000000100,
		S_WR   = 10'b0000001000,
		S_SLRD = 10'b0000010000,
		S_SLWR = 10'b0000100000,
		S_SRRD = 10'b0001000000,
		S_SRWR = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				case (sts.act)
					ACT_WR, ACT_WR_REMOVE: state_d = S_WR;
					ACT_REMOVE:            state_d = S_SLRD;
					ACT_INSERT:            state_d = S_SRRD;
					default:               state_d = S_FIN;
				endcase
			end
			S_WR: begin
				cmd.wr_ent = 1'b1;
				state_d = (sts.act_q == ACT_WR_REMOVE) ? S_SLRD : S_FIN;
			end
			S_SLRD: begin
				if (sts.sl_more) begin
					cmd.sl_rd = 1'b1;
					state_d = S_SLWR;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SLWR: begin
				cmd.sl_wr = 1'b1;
				state_d = S_SLRD;
			end
			S_SRRD: begin
				if (sts.sr_more) begin
					cmd.sr_rd = 1'b1;
					state_d = S_SRWR;
				end else begin
					state_d = S_WR;
				end
			end
			S_SRWR: begin
				cmd.sr_wr = 1'b1;
				state_d = S_SRRD;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hdl/ffpa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: extent table memory, scan evaluation, decision and counters.
// ----------------------------------------------------------------------------
module ffpa_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [1:0]               operation,
	input  wire logic [ffpa_pkg::PW-1:0]  start_page,
	input  wire logic [ffpa_pkg::CW-1:0]  page_count,
	input  wire ffpa_pkg::cmd_t           cmd,
	output ffpa_pkg::sts_t                sts,
	output logic [1:0]                    status,
	output logic [ffpa_pkg::PW-1:0]       granted_page,
	output logic [ffpa_pkg::CW-1:0]       free_total
);
	import ffpa_pkg::*;

	localparam int XW = PW + 2;

	ext_t          mem_q [MAX_EXTENTS];
	ext_t          rdata_q;
	logic [IW-1:0] rd_addr;
	logic          we;
	logic [IW-1:0] wa;
	ext_t          wd;

	op_t           op_q;
	logic [PW-1:0] s_q;
	logic [CW-1:0] n_q;
	logic          skip_q;
	logic [UW-1:0] used_q;
	logic [CW-1:0] free_q;
	logic [UW-1:0] sp_q;
	logic          rv_s1;
	logic [IW-1:0] ridx_s1;
	logic          ovl_q, nxt_v_q, fnd_q;
	logic [UW-1:0] pos_q;
	ext_t          prev_q, nxt_q, fent_q;
	logic [IW-1:0] fidx_q;
	logic [UW-1:0] p_q;
	ext_t          wr_ent_q;
	logic [IW-1:0] wr_idx_q;
	act_t          act_q;
	status_t       status_q;
	logic [PW-1:0] granted_q;

	logic [XW-1:0] room, n_ext, e_end, s_end;
	logic [CW-1:0] n_clip;
	logic          ml, mr, ok, chg;
	act_t          act;
	status_t       st_d;
	ext_t          ent_d;
	logic [IW-1:0] idx_d;
	logic [UW-1:0] p_d;

	assign room  = XW'(NUM_PAGES) - {2'b0, start_page};
	assign n_ext = {1'b0, page_count};
	assign n_clip = (n_ext > room) ? room[CW-1:0] : page_count;

	assign e_end = {2'b0, rdata_q.st} + {1'b0, rdata_q.len};
	assign s_end = {2'b0, s_q} + {1'b0, n_q};

	assign ml = (op_q == OP_FREE) && (pos_q != '0) &&
		(({2'b0, prev_q.st} + {1'b0, prev_q.len}) == {2'b0, s_q});
	assign mr = (op_q == OP_FREE) && nxt_v_q && (s_end == {2'b0, nxt_q.st});

	always_comb begin
		act   = ACT_NONE;
		st_d  = ST_DONE;
		ent_d = fent_q;
		idx_d = fidx_q;
		p_d   = {1'b0, fidx_q};
		case (op_q)
			OP_ALLOC: begin
				if (n_q == '0 || n_q > free_q || !fnd_q) begin
					st_d = ST_NOFIT;
				end else if (fent_q.len == n_q) begin
					act = ACT_REMOVE;
				end else begin
					act = ACT_WR;
					ent_d.st  = fent_q.st + n_q[PW-1:0];
					ent_d.len = fent_q.len - n_q;
				end
			end
			OP_ADD, OP_FREE: begin
				if (skip_q) begin
					act = ACT_NONE;
				end else if (ovl_q) begin
					st_d = ST_NOFIT;
				end else if (ml && mr) begin
					act = ACT_WR_REMOVE;
					idx_d = IW'(pos_q - 1'b1);
					ent_d.st  = prev_q.st;
					ent_d.len = prev_q.len + n_q + nxt_q.len;
					p_d = pos_q;
				end else if (ml) begin
					act = ACT_WR;
					idx_d = IW'(pos_q - 1'b1);
					ent_d.st  = prev_q.st;
					ent_d.len = prev_q.len + n_q;
				end else if (mr) begin
					act = ACT_WR;
					idx_d = pos_q[IW-1:0];
					ent_d.st  = s_q;
					ent_d.len = nxt_q.len + n_q;
				end else if (used_q >= UW'(MAX_EXTENTS)) begin
					st_d = ST_FULL;
				end else begin
					act = ACT_INSERT;
					idx_d = pos_q[IW-1:0];
					ent_d.st  = s_q;
					ent_d.len = n_q;
					p_d = used_q;
				end
			end
			default: act = ACT_NONE;
		endcase
	end

	assign ok  = (st_d == ST_DONE);
	assign chg = ok && !skip_q && (op_q != OP_NONE);

	assign sts.scan_done = (sp_q >= used_q) && !rv_s1;
	assign sts.act       = act;
	assign sts.act_q     = act_q;
	assign sts.sl_more   = (p_q + 1'b1) < used_q;
	assign sts.sr_more   = p_q > pos_q;

	always_comb begin
		rd_addr = sp_q[IW-1:0];
		if (cmd.sl_rd) rd_addr = IW'(p_q + 1'b1);
		if (cmd.sr_rd) rd_addr = IW'(p_q - 1'b1);
		we = cmd.wr_ent || cmd.sl_wr || cmd.sr_wr;
		wa = cmd.wr_ent ? wr_idx_q : p_q[IW-1:0];
		wd = cmd.wr_ent ? wr_ent_q : rdata_q;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[rd_addr];
		if (we) mem_q[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op_t'(operation);
			s_q    <= start_page;
			n_q    <= (op_t'(operation) == OP_ALLOC) ? page_count : n_clip;
			skip_q <= (page_count == '0) || ({2'b0, start_page} >= XW'(NUM_PAGES));
			ovl_q   <= 1'b0;
			nxt_v_q <= 1'b0;
			fnd_q   <= 1'b0;
			pos_q   <= '0;
		end
		if (rv_s1) begin
			if ({2'b0, s_q} < e_end && {2'b0, rdata_q.st} < s_end) ovl_q <= 1'b1;
			if (rdata_q.st <= s_q) begin
				pos_q  <= {1'b0, ridx_s1} + 1'b1;
				prev_q <= rdata_q;
			end else if (!nxt_v_q) begin
				nxt_v_q <= 1'b1;
				nxt_q   <= rdata_q;
			end
			if (!fnd_q && rdata_q.len >= n_q) begin
				fnd_q  <= 1'b1;
				fidx_q <= ridx_s1;
				fent_q <= rdata_q;
			end
		end
		if (cmd.scan) ridx_s1 <= sp_q[IW-1:0];
		if (cmd.decide) begin
			wr_ent_q  <= ent_d;
			wr_idx_q  <= idx_d;
			act_q     <= act;
			status_q  <= st_d;
			granted_q <= (op_q == OP_ALLOC && ok) ? fent_q.st : '0;
			p_q       <= p_d;
		end
		if (cmd.sl_wr) p_q <= p_q + 1'b1;
		if (cmd.sr_wr) p_q <= p_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			free_q <= '0;
			sp_q   <= '0;
			rv_s1  <= 1'b0;
		end else begin
			if (cmd.cap) begin
				sp_q  <= '0;
				rv_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rv_s1 <= sp_q < used_q;
				if (sp_q < used_q) sp_q <= sp_q + 1'b1;
			end else begin
				rv_s1 <= 1'b0;
			end
			if (cmd.decide && chg) begin
				if (op_q == OP_ALLOC) free_q <= free_q - n_q;
				else                  free_q <= free_q + n_q;
			end
			if (cmd.fin) begin
				case (act_q)
					ACT_INSERT:                used_q <= used_q + 1'b1;
					ACT_REMOVE, ACT_WR_REMOVE: used_q <= used_q - 1'b1;
					default:                   used_q <= used_q;
				endcase
			end
		end
	end

	assign status       = status_q;
	assign granted_page = granted_q;
	assign free_total   = free_q;

endmodule
`default_nettype wire
